FILE: rtl/cartridge_bank_mapper_unit_assert.svh
// Assertion macros for the cartridge bank mapper RTL.
// Depends on nothing; the assertions compile out when SYNTHESIS is defined.
`ifndef CARTRIDGE_BANK_MAPPER_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CBM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define CBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/cbm_pkg.sv
// Shared constants, codes and helper functions of the cartridge bank mapper.
// Depends on nothing; used by the channel interfaces and the top level.
package cbm_pkg;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int KIND_W   = 2;
   localparam int ROM_AW   = 23;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam int ROM_BANK_BYTES    = 16384;
   localparam int RAM_BANK_BYTES    = 8192;
   localparam int RAM_BANKS_DEF     = 16;
   localparam int MAX_ROM_BANKS_DEF = 512;

   // Bus access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ROM      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RAM      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNMAPPED = 2'd3;

   // Register indexes on the configuration port.
   localparam logic REG_ROM_SIZE = 1'b0;
   localparam logic REG_RAM_SIZE = 1'b1;

   // Address map.
   localparam logic [ADDR_W-1:0] RAM_EN_END    = 16'h1FFF;
   localparam logic [ADDR_W-1:0] ROM_LOW_END   = 16'h2FFF;
   localparam logic [ADDR_W-1:0] ROM_HIGH_END  = 16'h3FFF;
   localparam logic [ADDR_W-1:0] RAM_BANK_END  = 16'h5FFF;
   localparam logic [ADDR_W-1:0] ROM_WIN_END   = 16'h7FFF;
   localparam logic [ADDR_W-1:0] RAM_WIN_START = 16'hA000;
   localparam logic [ADDR_W-1:0] RAM_WIN_END   = 16'hBFFF;

   localparam logic [DATA_W-1:0] RAM_ENABLE_KEY  = 8'h0A;
   localparam logic [DATA_W-1:0] RAM_DISABLE_KEY = 8'h00;
   localparam logic [DATA_W-1:0] OPEN_BUS        = 8'hFF;

   // Bank count for each RAM size code; codes six and seven wrap.
   function automatic logic [4:0] ram_bank_table(input logic [2:0] code);
      logic [4:0] n;
      case (code)
         3'd0:    n = 5'd0;
         3'd1:    n = 5'd1;
         3'd2:    n = 5'd1;
         3'd3:    n = 5'd4;
         3'd4:    n = 5'd16;
         3'd5:    n = 5'd8;
         3'd6:    n = 5'd0;
         default: n = 5'd1;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/cbm_req_if.sv
// Request channel of the cartridge bank mapper: one CPU bus access per transfer.
// Depends on cbm_pkg for the field widths.
interface cbm_req_if;
   import cbm_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output opcode, output address, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input address, input write_data,
                   output ready);
endinterface

FILE: rtl/cbm_rsp_if.sv
// Response channel of the cartridge bank mapper: one result per bus access.
// Depends on cbm_pkg for the field widths.
interface cbm_rsp_if;
   import cbm_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] access_kind;
   logic [ROM_AW-1:0] rom_address;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, output access_kind, output rom_address,
                   output read_data, input ready);
   modport sink   (input valid, input access_kind, input rom_address,
                   input read_data, output ready);
endinterface

FILE: rtl/cartridge_bank_mapper_unit.sv
// Top level of the cartridge bank mapper: bank registers, banked RAM and result stage.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if and cartridge_bank_mapper_unit_assert.svh.

// The block takes one bus access per transfer and returns one result for it in the
// cycle after acceptance; it takes a new access every cycle as long as each result
// is taken, and a stalled result holds the input side until it is taken. Bank
// control writes take effect for the very next access. The internal RAM is a
// single-port synchronous memory of RAM_BANKS * 8192 bytes; after reset it is
// swept to zero, one byte a cycle, and req.ready stays low until the sweep ends.
// Configuration writes are taken at any time, including during that sweep.
`include "cartridge_bank_mapper_unit_assert.svh"

module cartridge_bank_mapper_unit #(
   parameter int RAM_BANKS     = cbm_pkg::RAM_BANKS_DEF,
   parameter int MAX_ROM_BANKS = cbm_pkg::MAX_ROM_BANKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   cbm_req_if.sink                   req,
   cbm_rsp_if.source                 rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [cbm_pkg::CSR_AW-1:0] paddr,
   input  logic [cbm_pkg::CSR_DW-1:0] pwdata,
   output logic [cbm_pkg::CSR_DW-1:0] prdata,
   output logic                      pready
);
   import cbm_pkg::*;

   localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   // Reciprocals for the remainder by the fixed bank caps; exact over the operand ranges.
   localparam int ROM_RECIP_SHIFT = 18;
   localparam int ROM_RECIP = ((1 << ROM_RECIP_SHIFT) + MAX_ROM_BANKS - 1) / MAX_ROM_BANKS;
   localparam int RAM_RECIP_SHIFT = 16;
   localparam int RAM_RECIP = ((1 << RAM_RECIP_SHIFT) + RAM_BANKS - 1) / RAM_BANKS;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic [3:0] rom_code_ff, rom_code_in;
   logic [2:0] ram_code_ff, ram_code_in;
   logic       ram_en_ff, ram_en_in;
   logic [7:0] rom_low_ff, rom_low_in;
   logic       rom_high_ff, rom_high_in;
   logic [3:0] ram_bank_ff, ram_bank_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ROM_AW-1:0] rom_addr_ff, rom_addr_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              from_ram_ff, from_ram_in;

   logic [DATA_W-1:0] ram_store_ff [RAM_DEPTH];
   logic [DATA_W-1:0] ram_q_ff;

   logic              accept;
   logic              csr_write;
   logic [4:0]        ram_count;
   logic              ram_ok;
   logic              in_ram_win;
   logic [8:0]        bank9;
   logic [9:0]        rom_mask;
   logic              use_mask;
   logic [25:0]       rom_prod;
   logic [17:0]       rom_qn;
   logic [8:0]        rom_rem;
   logic [8:0]        rom_bank;
   logic [23:0]       ram_prod;
   logic [15:0]       ram_qn;
   logic [7:0]        ram_rem;
   logic [3:0]        ram_mask;
   logic [3:0]        ram_bank_wrap;
   logic [16:0]       ram_addr_full;
   logic              mem_we;
   logic              mem_re;
   logic [RAM_AW-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wdata;

   assign req.ready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_RAM_SIZE) ? CSR_DW'(ram_code_ff)
                                                 : CSR_DW'(rom_code_ff);

   assign ram_count  = (ram_bank_table(ram_code_ff) > 5'(RAM_BANKS)) ? 5'(RAM_BANKS)
                                                                      : ram_bank_table(ram_code_ff);
   assign ram_ok     = ram_en_ff && (ram_count != 5'd0);
   assign in_ram_win = (req.address >= RAM_WIN_START) && (req.address <= RAM_WIN_END);

   // The ROM bank count is a power of two unless the cap cuts it short.
   assign bank9    = {rom_high_ff, rom_low_ff};
   assign rom_mask = (10'd2 << rom_code_ff) - 10'd1;
   assign use_mask = (rom_code_ff <= 4'd8) &&
                     ((11'd2 << rom_code_ff) <= 11'(MAX_ROM_BANKS));
   assign rom_prod = 26'(bank9) * 26'(ROM_RECIP);
   assign rom_qn   = {10'd0, rom_prod[25:18]} * 18'(MAX_ROM_BANKS);
   assign rom_rem  = bank9 - rom_qn[8:0];
   assign rom_bank = use_mask ? (bank9 & rom_mask[8:0]) : rom_rem;

   // The RAM bank count is either a power of two or the fitted bank count itself.
   assign ram_prod      = 24'(req.write_data) * 24'(RAM_RECIP);
   assign ram_qn        = {8'd0, ram_prod[23:16]} * 16'(RAM_BANKS);
   assign ram_rem       = req.write_data - ram_qn[7:0];
   assign ram_mask      = ram_count[3:0] - 4'd1;
   assign ram_bank_wrap = (ram_count == 5'(RAM_BANKS)) ? ram_rem[3:0]
                                                        : (req.write_data[3:0] & ram_mask);

   // The stored RAM bank is always below RAM_BANKS, so it needs no further wrap.
   assign ram_addr_full = {ram_bank_ff, req.address[12:0]};

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = ram_addr_full[RAM_AW-1:0];
      mem_wdata = req.write_data;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_cnt_ff;
         mem_wdata = '0;
      end else if (accept && in_ram_win && ram_ok) begin
         mem_we = (req.opcode == OP_WRITE);
         mem_re = (req.opcode == OP_READ);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rom_code_in  = rom_code_ff;
      ram_code_in  = ram_code_ff;
      ram_en_in    = ram_en_ff;
      rom_low_in   = rom_low_ff;
      rom_high_in  = rom_high_ff;
      ram_bank_in  = ram_bank_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      rom_addr_in  = rom_addr_ff;
      rd_in        = rd_ff;
      from_ram_in  = from_ram_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_write) begin
         case (paddr[2])
            REG_ROM_SIZE: rom_code_in = pwdata[3:0];
            REG_RAM_SIZE: ram_code_in = pwdata[2:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_WRITE;
         rom_addr_in  = '0;
         rd_in        = '0;
         from_ram_in  = 1'b0;
         if (req.opcode == OP_WRITE) begin
            if (req.address <= RAM_EN_END) begin
               if (req.write_data == RAM_ENABLE_KEY) begin
                  ram_en_in = 1'b1;
               end else if (req.write_data == RAM_DISABLE_KEY) begin
                  ram_en_in = 1'b0;
               end
            end else if (req.address <= ROM_LOW_END) begin
               rom_low_in = req.write_data;
            end else if (req.address <= ROM_HIGH_END) begin
               rom_high_in = req.write_data[0];
            end else if (req.address <= RAM_BANK_END) begin
               if (ram_count != 5'd0) begin
                  ram_bank_in = ram_bank_wrap;
               end
            end
         end else begin
            if (req.address <= ROM_HIGH_END) begin
               kind_in     = KIND_ROM;
               rom_addr_in = ROM_AW'(req.address);
            end else if (req.address <= ROM_WIN_END) begin
               kind_in     = KIND_ROM;
               rom_addr_in = {rom_bank, req.address[13:0]};
            end else if (in_ram_win) begin
               kind_in     = KIND_RAM;
               from_ram_in = ram_ok;
               rd_in       = OPEN_BUS;
            end else begin
               kind_in = KIND_UNMAPPED;
               rd_in   = OPEN_BUS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rom_code_ff  <= '0;
         ram_code_ff  <= '0;
         ram_en_ff    <= 1'b0;
         rom_low_ff   <= 8'd1;
         rom_high_ff  <= 1'b0;
         ram_bank_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rom_code_ff  <= rom_code_in;
         ram_code_ff  <= ram_code_in;
         ram_en_ff    <= ram_en_in;
         rom_low_ff   <= rom_low_in;
         rom_high_ff  <= rom_high_in;
         ram_bank_ff  <= ram_bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rom_addr_ff <= rom_addr_in;
      rd_ff       <= rd_in;
      from_ram_ff <= from_ram_in;
   end

   // Single-port RAM; the read data register only loads on a RAM read transfer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ram_store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         ram_q_ff <= ram_store_ff[mem_addr];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.access_kind = kind_ff;
   assign rsp.rom_address = rom_addr_ff;
   assign rsp.read_data   = from_ram_ff ? ram_q_ff : rd_ff;

   `CBM_ASSERT_SAME(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req.ready, "request accepted during RAM clear")
   `CBM_ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp.valid, "no result after an accepted transfer")
   `CBM_ASSERT_SAME(a_rom_addr_zero, clock, reset, rsp.valid && (rsp.access_kind != KIND_ROM), rsp.rom_address == '0, "ROM address set on a non-ROM result")
   `CBM_ASSERT_SAME(a_ram_bank_range, clock, reset, 1'b1, 32'(ram_bank_ff) < 32'(RAM_BANKS), "RAM bank beyond fitted banks")
   `CBM_ASSERT_NEXT(a_ram_data_read, clock, reset, accept && (req.opcode == OP_WRITE), !from_ram_ff, "write transfer returns RAM data")

endmodule

FILE: test/tb_cartridge_bank_mapper_unit.sv
// Self-checking testbench for cartridge_bank_mapper_unit: bus accesses go in, results are checked.
// A scoreboard class predicts every result from its own copy of the bank state and the RAM.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if and the RTL of the block.
module tb_cartridge_bank_mapper_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cbm_pkg::*;

   localparam int RAM_IMAGE_BYTES = RAM_BANKS_DEF * RAM_BANK_BYTES;
   // The RAM sweep after reset holds off the request side, and the stall limit allows for it.
   localparam int STALL_LIMIT     = 4 * RAM_IMAGE_BYTES;
   localparam int DRAIN_CYCLES    = 4;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 180;

   localparam logic [ADDR_W-1:0] ROM_WIN_START = 16'h4000;
   localparam int RAM_BANKS_BY_CODE [8] = '{0, 1, 1, 4, 16, 8, 0, 1};

   // ROM size code in the upper four bits, RAM size code in the lower three.
   localparam logic [6:0] PHASE_SETTINGS [PHASE_COUNT] = '{
      {4'd0, 3'd1}, {4'd15, 3'd7}, {4'd8, 3'd5}, {4'd3, 3'd3},
      {4'd1, 3'd6}, {4'd9, 3'd2}, {4'd5, 3'd4}, {4'd2, 3'd0}
   };

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ROM_AW-1:0] rom_addr;
      logic [DATA_W-1:0] data;
   } mapper_result_type;

   class mapper_scoreboard;
      logic [3:0]        rom_code;
      logic [2:0]        ram_code;
      bit                ram_on;
      logic [7:0]        bank_lo;
      bit                bank_hi;
      logic [3:0]        ram_sel;
      logic [DATA_W-1:0] ram_image [RAM_IMAGE_BYTES];
      mapper_result_type pending [$];
      int                errors;

      function new();
         rom_code = '0;
         ram_code = '0;
         ram_on   = 1'b0;
         bank_lo  = 8'd1;
         bank_hi  = 1'b0;
         ram_sel  = '0;
         errors   = 0;
         foreach (ram_image[i]) ram_image[i] = '0;
      endfunction

      function void set_register(logic idx, logic [CSR_DW-1:0] value);
         if (idx == REG_ROM_SIZE) begin
            rom_code = value[3:0];
         end else begin
            ram_code = value[2:0];
         end
      endfunction

      function int rom_banks();
         return (rom_code <= 4'd8) ? (2 << rom_code) : MAX_ROM_BANKS_DEF;
      endfunction

      function int ram_offset(logic [ADDR_W-1:0] a);
         return int'(ram_sel) * RAM_BANK_BYTES + int'(a - RAM_WIN_START);
      endfunction

      // Applies one accepted bus access to the state and queues the result it must give.
      function void note_access(logic op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
         mapper_result_type r;
         int nram;
         int bank;
         r    = '0;
         nram = RAM_BANKS_BY_CODE[ram_code];
         if (op == OP_WRITE) begin
            r.kind = KIND_WRITE;
            if (a <= RAM_EN_END) begin
               if (d == RAM_ENABLE_KEY) begin
                  ram_on = 1'b1;
               end else if (d == RAM_DISABLE_KEY) begin
                  ram_on = 1'b0;
               end
            end else if (a <= ROM_LOW_END) begin
               bank_lo = d;
            end else if (a <= ROM_HIGH_END) begin
               bank_hi = d[0];
            end else if (a <= RAM_BANK_END) begin
               if (nram != 0) ram_sel = 4'(int'(d) % nram);
            end else if (a >= RAM_WIN_START && a <= RAM_WIN_END) begin
               if (ram_on && nram != 0) ram_image[ram_offset(a)] = d;
            end
         end else begin
            if (a < ROM_WIN_START) begin
               r.kind     = KIND_ROM;
               r.rom_addr = ROM_AW'(a);
            end else if (a <= ROM_WIN_END) begin
               bank       = int'({bank_hi, bank_lo}) % rom_banks();
               r.kind     = KIND_ROM;
               r.rom_addr = ROM_AW'(bank * ROM_BANK_BYTES + int'(a - ROM_WIN_START));
            end else if (a >= RAM_WIN_START && a <= RAM_WIN_END) begin
               r.kind = KIND_RAM;
               r.data = (ram_on && nram != 0) ? ram_image[ram_offset(a)] : OPEN_BUS;
            end else begin
               r.kind = KIND_UNMAPPED;
               r.data = OPEN_BUS;
            end
         end
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         errors++;
      endtask

      task check_result(mapper_result_type got);
         mapper_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result kind %0d rom %h data %h with nothing outstanding",
                             got.kind, got.rom_addr, got.data));
         end else begin
            want = pending.pop_front();
            if (got.kind !== want.kind)
               report($sformatf("access_kind %0d, predicted %0d", got.kind, want.kind));
            if (got.rom_addr !== want.rom_addr)
               report($sformatf("rom_address %h, predicted %h", got.rom_addr, want.rom_addr));
            if (got.data !== want.data)
               report($sformatf("read_data %h, predicted %h", got.data, want.data));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   cbm_req_if req_ch ();
   cbm_rsp_if rsp_ch ();

   mapper_scoreboard sb;
   int idle_cycles = 0;
   int sink_hold   = 0;
   bit sink_steady = 1'b0;
   bit src_steady  = 1'b0;

   cartridge_bank_mapper_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Result side: random stalls, with stretches of constant readiness.
   always @(negedge clock) begin
      if (sink_hold == 0 && !sink_steady && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
      if ($urandom_range(0, 255) == 0) sink_steady = !sink_steady;
      if (sink_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         sink_hold--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      mapper_result_type got;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         // Results are checked before the new transfer is noted, so the queue order holds.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.access_kind, rsp_ch.rom_address, rsp_ch.read_data};
            sb.check_result(got);
            moved = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            sb.note_access(req_ch.opcode, req_ch.address, req_ch.write_data);
            moved = 1'b1;
         end
         if (psel && penable && pready) moved = 1'b1;
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_access(input logic op, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
      int gap;
      gap = src_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.address    <= a;
      req_ch.write_data <= d;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes a register, then reads it back.
   task automatic csr_write(input logic idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      psel    <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value)
         sb.report($sformatf("register %0d reads %h, written %h", idx, prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] pick_ram_address();
      logic [12:0] off;
      // Half the RAM traffic goes to a few hot bytes at both ends of a bank, so reads hit writes.
      if ($urandom_range(0, 1)) begin
         off = 13'($urandom_range(0, 7));
         if ($urandom_range(0, 1)) off = off | 13'h1FF8;
      end else begin
         off = 13'($urandom);
      end
      return {3'b101, off};
   endfunction

   task automatic send_random_access();
      logic              op;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] d;
      int                r;
      int                k;
      op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_READ;
      d  = DATA_W'($urandom);
      r  = $urandom_range(0, 99);
      if (op == OP_WRITE) begin
         if (r < 10) begin
            a = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
            k = $urandom_range(0, 9);
            if (k < 5) d = RAM_ENABLE_KEY;
            else if (k < 7) d = RAM_DISABLE_KEY;
         end else if (r < 20) begin
            a = ADDR_W'($urandom_range(16'h2000, 16'h2FFF));
         end else if (r < 28) begin
            a = ADDR_W'($urandom_range(16'h3000, 16'h3FFF));
         end else if (r < 38) begin
            a = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
         end else if (r < 83) begin
            a = pick_ram_address();
         end else if ($urandom_range(0, 1)) begin
            a = ADDR_W'($urandom_range(16'h6000, 16'h9FFF));
         end else begin
            a = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
         end
      end else begin
         if (r < 15) a = ADDR_W'($urandom_range(16'h0000, 16'h3FFF));
         else if (r < 50) a = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
         else if (r < 90) a = pick_ram_address();
         else if ($urandom_range(0, 1)) a = ADDR_W'($urandom_range(16'h8000, 16'h9FFF));
         else a = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
      end
      send_access(op, a, d);
   endtask

   initial begin
      sb                = new();
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_READ;
      req_ch.address    = '0;
      req_ch.write_data = '0;
      rsp_ch.ready      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes: two ROM banks and no RAM, so RAM stays open bus even when enabled.
      send_access(OP_READ,  16'h0000, 8'h00);
      send_access(OP_READ,  16'h7FFF, 8'hFF);
      send_access(OP_WRITE, 16'h0000, RAM_ENABLE_KEY);
      send_access(OP_WRITE, 16'hA000, 8'h55);
      send_access(OP_READ,  16'hA000, 8'h00);
      send_access(OP_READ,  16'hFFFF, 8'h00);
      drain();
      csr_write(REG_ROM_SIZE, 32'd8);
      csr_write(REG_RAM_SIZE, 32'd4);

      // Largest bank numbers, bank zero in the upper window, RAM banking and the enable keys.
      send_access(OP_WRITE, 16'h2000, 8'hFF);
      send_access(OP_WRITE, 16'h3FFF, 8'h01);
      send_access(OP_READ,  16'h4000, 8'h00);
      send_access(OP_READ,  16'h7FFF, 8'h00);
      send_access(OP_WRITE, 16'h3000, 8'hFE);
      send_access(OP_WRITE, 16'h2FFF, 8'h00);
      send_access(OP_READ,  16'h4000, 8'h00);
      send_access(OP_WRITE, 16'h4000, 8'h1F);
      send_access(OP_WRITE, 16'hBFFF, 8'hA5);
      send_access(OP_READ,  16'hBFFF, 8'h00);
      send_access(OP_WRITE, 16'h1FFF, 8'h07);
      send_access(OP_READ,  16'hBFFF, 8'h00);
      send_access(OP_WRITE, 16'h0000, RAM_DISABLE_KEY);
      send_access(OP_READ,  16'hBFFF, 8'h00);
      send_access(OP_WRITE, 16'h5FFF, 8'h00);
      send_access(OP_READ,  16'h8000, 8'h00);
      send_access(OP_WRITE, 16'h6000, 8'hFF);
      send_access(OP_WRITE, 16'hC000, 8'h5A);
      send_access(OP_READ,  16'h9FFF, 8'h00);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         csr_write(REG_ROM_SIZE, CSR_DW'(PHASE_SETTINGS[p][6:3]));
         csr_write(REG_RAM_SIZE, CSR_DW'(PHASE_SETTINGS[p][2:0]));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
            send_random_access();
         end
      end

      drain();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_req_if.sv
rtl/cbm_rsp_if.sv
rtl/cartridge_bank_mapper_unit.sv
test/tb_cartridge_bank_mapper_unit.sv
